>>> src/chained_xor_image_decoder_top_assert.svh
// Assertion macros used by the decoder core.
`ifndef CHAINED_XOR_IMAGE_DECODER_TOP_ASSERT_SVH
`define CHAINED_XOR_IMAGE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CXID_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cxid assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CXID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cxid assertion failed");

`endif

>>> src/cxid_pkg.sv
package cxid_pkg;

   // Image layout
   localparam int POS_W        = 8;
   localparam int SIG_BYTES    = 4;
   localparam int HEADER_BYTES = 8;

   // Keys and reset values
   localparam logic [15:0] HEADER_KEY      = 16'h4741;
   localparam logic [31:0] SIGNATURE_RESET = 32'h2D47_2D47;

   // Status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SIG_BAD = 2'd1;
   localparam logic [1:0] STATUS_SUM_BAD = 2'd2;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       data_valid;
      logic       image_done;
      logic [1:0] status;
   } rsp_item_type;

endpackage

>>> src/cxid_channels.sv
// Request channel: one raw image byte per request.
interface cxid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       image_start;

   modport source (output valid, in_byte, image_start, input ready);
   modport sink   (input valid, in_byte, image_start, output ready);
endinterface

// Response channel: decoded byte and image status.
interface cxid_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       data_valid;
   logic       image_done;
   logic [1:0] status;

   modport source (output valid, out_byte, data_valid, image_done, status, input ready);
   modport sink   (input valid, out_byte, data_valid, image_done, status, output ready);
endinterface

>>> src/cxid_core.sv
`include "chained_xor_image_decoder_top_assert.svh"

module cxid_core
   import cxid_pkg::*;
#(
   parameter int DATA_BYTES = 184
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               image_start,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   output logic               res_valid,
   output rsp_item_type       res_item
);

   localparam logic [POS_W-1:0] LAST_POS  = POS_W'(DATA_BYTES + HEADER_BYTES - 1);
   localparam logic [1:0]       DATA_LOW2 = 2'(DATA_BYTES % 4);

   logic [31:0]      sig_word_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             sig_good_ff, sig_good_in;
   logic             swallow_ff, swallow_in;
   logic [31:0]      stored_sum_ff, stored_sum_in;
   logic [15:0]      chain_key_ff, chain_key_in;
   logic [7:0]       held_low_ff, held_low_in;
   logic [31:0]      run_sum_ff, run_sum_in;

   // State as seen by this request, after an optional image restart
   logic [POS_W-1:0] eff_pos;
   logic             eff_good;
   logic             eff_swallow;
   logic [31:0]      eff_stored;
   logic [15:0]      eff_key;
   logic [7:0]       eff_held;
   logic [31:0]      eff_sum;

   logic [15:0] halfword;
   logic [15:0] hdr_dec;
   logic [31:0] new_stored;
   logic [7:0]  data_dec;
   logic [1:0]  shift_sel;
   logic [31:0] sum_add;

   // Restart view
   always_comb begin
      if (image_start) begin
         eff_pos     = '0;
         eff_good    = 1'b1;
         eff_swallow = 1'b0;
         eff_stored  = '0;
         eff_key     = HEADER_KEY;
         eff_held    = '0;
         eff_sum     = '0;
      end else begin
         eff_pos     = pos_ff;
         eff_good    = sig_good_ff;
         eff_swallow = swallow_ff;
         eff_stored  = stored_sum_ff;
         eff_key     = chain_key_ff;
         eff_held    = held_low_ff;
         eff_sum     = run_sum_ff;
      end
   end

   // Per-byte decode and next state
   always_comb begin
      pos_in        = eff_pos;
      sig_good_in   = eff_good;
      swallow_in    = eff_swallow;
      stored_sum_in = eff_stored;
      chain_key_in  = eff_key;
      held_low_in   = eff_held;
      run_sum_in    = eff_sum;
      res_valid     = 1'b0;
      res_item      = '0;
      halfword      = {in_byte, eff_held};
      hdr_dec       = halfword ^ eff_key;
      new_stored    = eff_stored;
      data_dec      = eff_pos[0] ? (in_byte ^ eff_key[15:8]) : (in_byte ^ eff_key[7:0]);
      shift_sel     = DATA_LOW2 - eff_pos[1:0];
      sum_add       = eff_sum + ({24'b0, data_dec} << {shift_sel, 3'b000});

      if (!eff_swallow) begin
         pos_in = eff_pos + 1'b1;
         if (eff_pos < POS_W'(SIG_BYTES)) begin
            // signature bytes
            sig_good_in = eff_good && (in_byte == sig_word_ff[{eff_pos[1:0], 3'b000} +: 8]);
            if (eff_pos == POS_W'(SIG_BYTES - 1) && !sig_good_in) begin
               swallow_in          = 1'b1;
               res_valid           = 1'b1;
               res_item.image_done = 1'b1;
               res_item.status     = STATUS_SIG_BAD;
            end
         end else if (eff_pos < POS_W'(HEADER_BYTES)) begin
            // checksum halfwords
            if (!eff_pos[0]) begin
               held_low_in = in_byte;
            end else begin
               if (eff_pos[1]) begin
                  new_stored = {hdr_dec, eff_stored[15:0]};
               end else begin
                  new_stored = {eff_stored[31:16], hdr_dec};
               end
               stored_sum_in = new_stored;
               if (eff_pos[1]) begin
                  chain_key_in = (new_stored[15:0] ^ new_stored[23:8] ^ new_stored[31:16])
                                 ^ HEADER_KEY;
               end else begin
                  chain_key_in = halfword;
               end
            end
         end else begin
            // data bytes
            if (!eff_pos[0]) begin
               held_low_in = in_byte;
            end else begin
               chain_key_in = halfword;
            end
            run_sum_in          = sum_add;
            res_valid           = 1'b1;
            res_item.out_byte   = data_dec;
            res_item.data_valid = 1'b1;
            if (eff_pos == LAST_POS) begin
               swallow_in          = 1'b1;
               res_item.image_done = 1'b1;
               res_item.status     = (sum_add == eff_stored) ? STATUS_OK : STATUS_SUM_BAD;
            end
         end
      end
   end

   // Signature register
   always_ff @(posedge clock) begin
      if (reset) begin
         sig_word_ff <= SIGNATURE_RESET;
      end else if (csr_wr_en) begin
         sig_word_ff <= csr_wr_data;
      end
   end

   // Image state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         sig_good_ff   <= 1'b1;
         swallow_ff    <= 1'b0;
         stored_sum_ff <= '0;
         chain_key_ff  <= HEADER_KEY;
         held_low_ff   <= '0;
         run_sum_ff    <= '0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         sig_good_ff   <= sig_good_in;
         swallow_ff    <= swallow_in;
         stored_sum_ff <= stored_sum_in;
         chain_key_ff  <= chain_key_in;
         held_low_ff   <= held_low_in;
         run_sum_ff    <= run_sum_in;
      end
   end

   `CXID_ASSERT_NOW(a_swallow_quiet, clock, reset, accept && swallow_ff && !image_start, !res_valid)
   `CXID_ASSERT_NEXT(a_done_swallows, clock, reset, accept && res_valid && res_item.image_done, swallow_ff)
   `CXID_ASSERT_NEXT(a_pos_steps, clock, reset, accept && !swallow_ff && !image_start, pos_ff == POS_W'($past(pos_ff) + 1'b1))
   `CXID_ASSERT_NOW(a_data_after_hdr, clock, reset, accept && res_valid && res_item.data_valid, eff_pos >= POS_W'(HEADER_BYTES))

endmodule

>>> src/cxid_out_stage.sv
module cxid_out_stage
   import cxid_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item,
   output logic         in_ready,
   cxid_rsp_if.source   rsp
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // Room when empty or when the held response leaves this cycle
   assign in_ready = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.out_byte   = item_ff.out_byte;
   assign rsp.data_valid = item_ff.data_valid;
   assign rsp.image_done = item_ff.image_done;
   assign rsp.status     = item_ff.status;

endmodule

>>> src/chained_xor_image_decoder_top.sv
// Chained-XOR image decoder. Takes one encoded image byte per request: four
// signature bytes (checked against csr_wr_data's last written value, or
// SIGNATURE_RESET after reset, little endian), four checksum bytes, then
// DATA_BYTES data bytes, each decoded and returned in its own response together
// with a final status on the last one. A request with image_start high begins
// a new image; after reset the first byte is byte 0. A signature mismatch gives
// one status-only response at byte 3 and the rest of the image produces none.
// A request is accepted in every cycle the single response register is empty
// or being drained, and its response appears on the next cycle. Throughput is
// one byte per clock while the response register is not held full by a stalled
// response, since each request needs one pass through the decode logic.
module chained_xor_image_decoder_top
   import cxid_pkg::*;
#(
   parameter int DATA_BYTES = 184
) (
   input  logic        clock,
   input  logic        reset,
   cxid_req_if.sink    req_bus,
   cxid_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic         accept;
   logic         stage_ready;
   logic         res_valid;
   rsp_item_type res_item;

   assign req_bus.ready = stage_ready;
   assign accept        = req_bus.valid && stage_ready;

   cxid_core #(
      .DATA_BYTES (DATA_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_bus.in_byte),
      .image_start (req_bus.image_start),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res_valid   (res_valid),
      .res_item    (res_item)
   );

   cxid_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (accept && res_valid),
      .item     (res_item),
      .in_ready (stage_ready),
      .rsp      (rsp_bus)
   );

endmodule
